>>> rtl/tts_pkg.sv
// Shared types and constants of the task table round-robin scheduler.
`default_nettype none

package tts_pkg;

    // Default table geometry
    localparam int TTS_NUM_TASKS  = 16;
    localparam int TTS_SLOT_BYTES = 2048;

    // Initial exception frame pushed below the stack top
    localparam int          FRAME_WORDS = 17;
    localparam logic [31:0] FRAME_BYTES = 32'(FRAME_WORDS * 4);
    localparam logic [31:0] FRAME_NEG   = 32'd0 - FRAME_BYTES;

    // Stack sizes must be a multiple of eight bytes
    localparam logic [15:0] ALIGN_MASK = 16'h0007;

    // Reset value of the minimum stack size register
    localparam logic [15:0] MIN_STACK_RESET = 16'd512;

    // Register select, taken from paddr[2]
    localparam logic REG_BASE = 1'b0;
    localparam logic REG_MIN  = 1'b1;

    // Operation codes carried by an item
    typedef enum logic [2:0] {
        OP_INIT   = 3'd0,
        OP_CREATE = 3'd1,
        OP_START  = 3'd2,
        OP_YIELD  = 3'd3,
        OP_EXIT   = 3'd4,
        OP_SWITCH = 3'd5,
        OP_INFO   = 3'd6,
        OP_GETID  = 3'd7
    } tts_op_t;

    // Per-slot task state
    typedef enum logic [1:0] {
        TS_DORMANT = 2'd0,
        TS_READY   = 2'd1,
        TS_RUNNING = 2'd2
    } tts_tstate_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FREE,
        S_CHECK,
        S_CALC_TOP,
        S_CALC_SP,
        S_PICK,
        S_SAVE,
        S_SW_CHK,
        S_SW_READ,
        S_EXIT,
        S_INFO_CHK
    } tts_fsm_t;

    // Write request into the task record memory
    typedef struct packed {
        logic        entry_we;
        logic        size_we;
        logic        sp_we;
        logic [31:0] entry;
        logic [15:0] size;
        logic [31:0] sp;
    } tts_wr_t;

    // One task record as read back
    typedef struct packed {
        logic [31:0] entry;
        logic [15:0] size;
        logic [31:0] sp;
    } tts_rec_t;

    // One result item
    typedef struct packed {
        logic        status;
        logic [3:0]  id;
        logic [31:0] top;
        logic [31:0] sp;
        logic [1:0]  tstate;
        logic [31:0] entry;
        logic [15:0] size;
        logic        req;
    } tts_res_t;

endpackage

`default_nettype wire

>>> rtl/tts_table.sv
// Task record memory: entry address, stack size and saved stack pointer per slot.
`default_nettype none

module tts_table
    import tts_pkg::*;
#(
    parameter int NUM_TASKS = TTS_NUM_TASKS
)
(
    input  wire logic                         clk,
    input  wire logic [$clog2(NUM_TASKS)-1:0] addr,
    input  wire tts_wr_t                      wr,
    output tts_rec_t                          rd
);

    logic [31:0] entry_mem [NUM_TASKS];
    logic [15:0] size_mem  [NUM_TASKS];
    logic [31:0] sp_mem    [NUM_TASKS];
    tts_rec_t    rd_reg;

    // Write the selected fields of one record
    always_ff @(posedge clk)
    begin
        if (wr.entry_we)
        begin
            entry_mem[addr] <= wr.entry;
        end
        if (wr.size_we)
        begin
            size_mem[addr] <= wr.size;
        end
        if (wr.sp_we)
        begin
            sp_mem[addr] <= wr.sp;
        end
    end

    // Read the addressed record every cycle, registered
    always_ff @(posedge clk)
    begin
        rd_reg.entry <= entry_mem[addr];
        rd_reg.size  <= size_mem[addr];
        rd_reg.sp    <= sp_mem[addr];
    end

    assign rd = rd_reg;

endmodule

`default_nettype wire

>>> rtl/task_table_round_robin_scheduler.sv
// Task table with round-robin scheduler: register port, sequencer and slot state.
// Get-id, yield and a start or info rejected on entry answer in the cycle after the item
// is taken; exit, init and info pass through further sequencer states; create, start and
// switch scan the table one slot per cycle while busy.
// busy stays high until the result strobe; the next item can be taken in that cycle.
// The result is shown on done for one cycle. Reset clears all slots to dormant.
`default_nettype none

module task_table_round_robin_scheduler
    import tts_pkg::*;
#(
    parameter int NUM_TASKS  = TTS_NUM_TASKS,
    parameter int SLOT_BYTES = TTS_SLOT_BYTES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Item in
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  mode,
    input  wire logic [15:0] stack_bytes,
    input  wire logic [31:0] entry_addr,
    input  wire logic [3:0]  query_id,
    input  wire logic [31:0] outgoing_sp,
    // Result out
    output logic             done,
    output logic             status,
    output logic      [3:0]  id_out,
    output logic      [31:0] stack_top_out,
    output logic      [31:0] sp_out,
    output logic      [1:0]  state_out,
    output logic      [31:0] entry_out,
    output logic      [15:0] size_out,
    output logic             switch_request
);

    localparam int IDX_W = $clog2(NUM_TASKS);
    localparam int CNT_W = $clog2(NUM_TASKS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TASKS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NUM_TASKS);

    // Configuration registers
    logic [31:0] base_reg;
    logic [15:0] min_reg;

    // Sequencer and item registers
    tts_fsm_t          fsm_reg,    fsm_next;
    tts_op_t           op_reg,     op_next;
    logic [15:0]       sbytes_reg, sbytes_next;
    logic [31:0]       entry_reg,  entry_next;
    logic [31:0]       osp_reg,    osp_next;
    logic [IDX_W-1:0]  idx_reg,    idx_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic              found_reg,  found_next;
    logic [31:0]       top_reg,    top_next;

    // Scheduler state
    logic [IDX_W-1:0]  cur_reg,    cur_next;
    logic              init_reg,   init_next;
    logic              run_reg,    run_next;
    tts_tstate_t       state_reg  [NUM_TASKS];
    tts_tstate_t       state_next [NUM_TASKS];

    // Result
    tts_res_t          res_reg,    res_next;
    logic              done_reg,   done_next;

    // Datapath
    logic              accept;
    logic              cfg_wr;
    tts_op_t           op_in;
    tts_tstate_t       cur_st;
    logic [IDX_W-1:0]  idx_inc;
    logic [IDX_W-1:0]  cur_inc;
    logic [IDX_W:0]    slot_num;
    logic [31:0]       slot_off;
    logic [31:0]       add_a;
    logic [31:0]       add_b;
    logic [31:0]       add_sum;
    logic              pick_hit;
    logic              create_err;
    tts_wr_t           wr;
    tts_rec_t          rd;

    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign op_in  = tts_op_t'(mode);

    // Register port: always ready, decode on paddr[2]
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN) ? {16'd0, min_reg} : base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= 32'd0;
            min_reg  <= MIN_STACK_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_BASE: base_reg <= pwdata;
                REG_MIN:  min_reg  <= pwdata[15:0];
                default:  base_reg <= base_reg;
            endcase
        end
    end

    // Slot state at the sequencer's index
    assign cur_st  = state_reg[idx_reg];
    assign idx_inc = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign cur_inc = (cur_reg == LAST_IDX) ? '0 : cur_reg + 1'b1;

    // Shared adder: stack top, then top minus the initial frame
    assign slot_num = {1'b0, idx_reg} + 1'b1;
    assign slot_off = 32'(32'(slot_num) * 32'(SLOT_BYTES));
    assign add_a    = (fsm_reg == S_CALC_SP) ? top_reg : base_reg;
    assign add_b    = (fsm_reg == S_CALC_SP) ? FRAME_NEG : slot_off;
    assign add_sum  = add_a + add_b;

    assign pick_hit = (idx_reg != '0) && (cur_st == TS_READY);

    assign create_err = !init_reg || (entry_reg == 32'd0) || (sbytes_reg < min_reg) ||
                        ((sbytes_reg & ALIGN_MASK) != 16'd0) || !found_reg ||
                        (32'(sbytes_reg) > 32'(SLOT_BYTES));

    // Next state and outputs of the sequencer
    always_comb
    begin
        fsm_next    = fsm_reg;
        op_next     = op_reg;
        sbytes_next = sbytes_reg;
        entry_next  = entry_reg;
        osp_next    = osp_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        found_next  = found_reg;
        top_next    = top_reg;
        cur_next    = cur_reg;
        init_next   = init_reg;
        run_next    = run_reg;
        state_next  = state_reg;
        res_next    = res_reg;
        done_next   = 1'b0;
        wr          = '0;

        case (fsm_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = op_in;
                    sbytes_next = stack_bytes;
                    entry_next  = entry_addr;
                    osp_next    = outgoing_sp;
                    case (op_in)
                        OP_INIT:
                        begin
                            idx_next = '0;
                            fsm_next = S_CALC_TOP;
                        end
                        OP_CREATE:
                        begin
                            idx_next = IDX_W'(1);
                            fsm_next = S_FREE;
                        end
                        OP_START:
                        begin
                            if (!init_reg || run_reg)
                            begin
                                res_next        = '0;
                                res_next.status = 1'b1;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                idx_next = cur_inc;
                                cnt_next = CNT_W'(1);
                                fsm_next = S_PICK;
                            end
                        end
                        OP_YIELD:
                        begin
                            res_next     = '0;
                            res_next.req = run_reg;
                            done_next    = 1'b1;
                        end
                        OP_EXIT:
                        begin
                            idx_next = cur_reg;
                            fsm_next = S_EXIT;
                        end
                        OP_SWITCH:
                        begin
                            idx_next = cur_reg;
                            fsm_next = S_SAVE;
                        end
                        OP_INFO:
                        begin
                            if (!init_reg || (32'(query_id) >= 32'(NUM_TASKS)))
                            begin
                                res_next        = '0;
                                res_next.status = 1'b1;
                                done_next       = 1'b1;
                            end
                            else
                            begin
                                idx_next = IDX_W'(query_id);
                                fsm_next = S_INFO_CHK;
                            end
                        end
                        default:
                        begin
                            res_next    = '0;
                            res_next.id = run_reg ? 4'(cur_reg) : 4'd0;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end

            // Find the first dormant user slot
            S_FREE:
            begin
                if (cur_st == TS_DORMANT)
                begin
                    found_next = 1'b1;
                    fsm_next   = S_CHECK;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    found_next = 1'b0;
                    fsm_next   = S_CHECK;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            // Validate a create request
            S_CHECK:
            begin
                if (create_err)
                begin
                    res_next        = '0;
                    res_next.status = 1'b1;
                    done_next       = 1'b1;
                    fsm_next        = S_IDLE;
                end
                else
                begin
                    fsm_next = S_CALC_TOP;
                end
            end

            // Stack top of the indexed slot; info finishes here
            S_CALC_TOP:
            begin
                top_next = add_sum;
                if (op_reg == OP_INFO)
                begin
                    res_next        = '0;
                    res_next.id     = 4'(idx_reg);
                    res_next.top    = add_sum;
                    res_next.sp     = rd.sp;
                    res_next.tstate = cur_st;
                    res_next.entry  = rd.entry;
                    res_next.size   = rd.size;
                    done_next       = 1'b1;
                    fsm_next        = S_IDLE;
                end
                else
                begin
                    fsm_next = S_CALC_SP;
                end
            end

            // Initial stack pointer; commit init or create
            S_CALC_SP:
            begin
                wr.entry_we = 1'b1;
                wr.size_we  = 1'b1;
                wr.sp_we    = 1'b1;
                wr.sp       = add_sum;
                res_next    = '0;
                if (op_reg == OP_INIT)
                begin
                    wr.entry = 32'd0;
                    wr.size  = min_reg;
                    for (int i = 0; i < NUM_TASKS; i++)
                    begin
                        state_next[i] = TS_DORMANT;
                    end
                    state_next[0] = TS_READY;
                    cur_next      = '0;
                    run_next      = 1'b0;
                    init_next     = 1'b1;
                end
                else
                begin
                    wr.entry              = entry_reg;
                    wr.size               = sbytes_reg;
                    state_next[idx_reg]   = TS_READY;
                    res_next.id           = 4'(idx_reg);
                    res_next.top          = top_reg;
                    res_next.sp           = add_sum;
                end
                done_next = 1'b1;
                fsm_next  = S_IDLE;
            end

            // Round-robin search for the next ready user task
            S_PICK:
            begin
                if (pick_hit || (cnt_reg == CNT_FULL))
                begin
                    if (op_reg == OP_START)
                    begin
                        res_next = '0;
                        if (pick_hit)
                        begin
                            run_next     = 1'b1;
                            res_next.req = 1'b1;
                        end
                        else
                        begin
                            res_next.status = 1'b1;
                        end
                        done_next = 1'b1;
                        fsm_next  = S_IDLE;
                    end
                    else
                    begin
                        if (!pick_hit)
                        begin
                            idx_next = '0;
                        end
                        fsm_next = S_SW_CHK;
                    end
                end
                else
                begin
                    idx_next = idx_inc;
                    cnt_next = CNT_W'(cnt_reg + 1'b1);
                end
            end

            // Save the outgoing task's stack pointer
            S_SAVE:
            begin
                if ((osp_reg != 32'd0) && (cur_st == TS_RUNNING))
                begin
                    wr.sp_we            = 1'b1;
                    wr.sp               = osp_reg;
                    state_next[idx_reg] = TS_READY;
                end
                idx_next = cur_inc;
                cnt_next = CNT_W'(1);
                fsm_next = S_PICK;
            end

            // Resume the picked task, or hold the current one
            S_SW_CHK:
            begin
                if (cur_st == TS_READY)
                begin
                    cur_next            = idx_reg;
                    state_next[idx_reg] = TS_RUNNING;
                    fsm_next            = S_SW_READ;
                end
                else
                begin
                    res_next    = '0;
                    res_next.id = 4'(cur_reg);
                    res_next.sp = osp_reg;
                    done_next   = 1'b1;
                    fsm_next    = S_IDLE;
                end
            end

            S_SW_READ:
            begin
                res_next    = '0;
                res_next.id = 4'(idx_reg);
                res_next.sp = rd.sp;
                done_next   = 1'b1;
                fsm_next    = S_IDLE;
            end

            // Drop the running task
            S_EXIT:
            begin
                res_next = '0;
                if (run_reg && (cur_reg != '0) && (cur_st == TS_RUNNING))
                begin
                    state_next[idx_reg] = TS_DORMANT;
                    res_next.req        = 1'b1;
                end
                else
                begin
                    res_next.status = 1'b1;
                end
                done_next = 1'b1;
                fsm_next  = S_IDLE;
            end

            // Queried slot must be in use; record read starts here
            S_INFO_CHK:
            begin
                if (cur_st == TS_DORMANT)
                begin
                    res_next        = '0;
                    res_next.status = 1'b1;
                    done_next       = 1'b1;
                    fsm_next        = S_IDLE;
                end
                else
                begin
                    fsm_next = S_CALC_TOP;
                end
            end

            default:
            begin
                fsm_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsm_reg  <= S_IDLE;
            cur_reg  <= '0;
            init_reg <= 1'b0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                state_reg[i] <= TS_DORMANT;
            end
        end
        else
        begin
            fsm_reg   <= fsm_next;
            cur_reg   <= cur_next;
            init_reg  <= init_next;
            run_reg   <= run_next;
            done_reg  <= done_next;
            state_reg <= state_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        sbytes_reg <= sbytes_next;
        entry_reg  <= entry_next;
        osp_reg    <= osp_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        found_reg  <= found_next;
        top_reg    <= top_next;
        res_reg    <= res_next;
    end

    tts_table #(
        .NUM_TASKS (NUM_TASKS)
    ) u_table (
        .clk  (clk),
        .addr (idx_reg),
        .wr   (wr),
        .rd   (rd)
    );

    assign busy           = (fsm_reg != S_IDLE);
    assign done           = done_reg;
    assign status         = res_reg.status;
    assign id_out         = res_reg.id;
    assign stack_top_out  = res_reg.top;
    assign sp_out         = res_reg.sp;
    assign state_out      = res_reg.tstate;
    assign entry_out      = res_reg.entry;
    assign size_out       = res_reg.size;
    assign switch_request = res_reg.req;

endmodule

`default_nettype wire

>>> rtl/tts_checker.sv
// Port-level checks of the task table scheduler, bound to the top level.
`default_nettype none

module tts_checker
    import tts_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [2:0]  mode,
    input wire logic        done,
    input wire logic        status,
    input wire logic [3:0]  id_out,
    input wire logic [31:0] stack_top_out,
    input wire logic [31:0] sp_out,
    input wire logic [1:0]  state_out,
    input wire logic [31:0] entry_out,
    input wire logic [15:0] size_out,
    input wire logic        switch_request
);

    // A result only shows once its item has left the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
    else $error("result strobe while busy");

    // No result without an item in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
    else $error("result strobe without an item");

    // Yield answers in the next cycle and never fails
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == OP_YIELD)) |=> (done && !status))
    else $error("yield result missing or failed");

    // Init always runs the table setup sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == OP_INIT)) |=> busy)
    else $error("init did not start the sequencer");

    // An error clears every other result field
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> ((id_out == 4'd0) && (stack_top_out == 32'd0) &&
                              (sp_out == 32'd0) && (state_out == 2'd0) &&
                              (entry_out == 32'd0) && (size_out == 16'd0) &&
                              !switch_request))
    else $error("error result carries data");

endmodule

bind task_table_round_robin_scheduler tts_checker u_checker (.*);

`default_nettype wire

>>> verif/task_table_round_robin_scheduler_test.sv
// Testbench for the task table round-robin scheduler: directed and random kernel calls.
`default_nettype none

module task_table_round_robin_scheduler_test;
    import tts_pkg::*;

    localparam int NUM_TASKS   = TTS_NUM_TASKS;
    localparam int SLOT_BYTES  = TTS_SLOT_BYTES;
    localparam int STALL_LIMIT = 400;
    localparam int PER_PHASE   = 80;
    localparam int NUM_PHASES  = 5;

    // Register byte addresses
    localparam logic [2:0] ADDR_BASE = 3'd0;
    localparam logic [2:0] ADDR_MIN  = 3'd4;

    // One kernel call as driven on the item ports
    typedef struct {
        tts_op_t     op;
        logic [15:0] sbytes;
        logic [31:0] entry;
        logic [3:0]  qid;
        logic [31:0] osp;
    } call_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start       = 1'b0;
    logic        busy;
    logic [2:0]  mode        = '0;
    logic [15:0] stack_bytes = '0;
    logic [31:0] entry_addr  = '0;
    logic [3:0]  query_id    = '0;
    logic [31:0] outgoing_sp = '0;
    logic        done;
    logic        status;
    logic [3:0]  id_out;
    logic [31:0] stack_top_out;
    logic [31:0] sp_out;
    logic [1:0]  state_out;
    logic [31:0] entry_out;
    logic [15:0] size_out;
    logic        switch_request;

    // Mirror of the task table and the registers
    tts_tstate_t slot_state [NUM_TASKS];
    logic [31:0] slot_entry [NUM_TASKS];
    logic [15:0] slot_size  [NUM_TASKS];
    logic [31:0] slot_sp    [NUM_TASKS];
    logic [3:0]  cur_task;
    logic        table_ready;
    logic        sched_on;
    logic [31:0] area_base;
    logic [15:0] min_stack;

    tts_res_t reply_q [$];
    tts_res_t want_reply;

    logic start_high = 1'b0;
    logic gaps_on    = 1'b1;
    int   errors     = 0;
    int   items_sent = 0;
    int   replies    = 0;
    int   reg_writes = 0;
    int   stall_cnt  = 0;

    task_table_round_robin_scheduler #(
        .NUM_TASKS  (NUM_TASKS),
        .SLOT_BYTES (SLOT_BYTES)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .stack_bytes    (stack_bytes),
        .entry_addr     (entry_addr),
        .query_id       (query_id),
        .outgoing_sp    (outgoing_sp),
        .done           (done),
        .status         (status),
        .id_out         (id_out),
        .stack_top_out  (stack_top_out),
        .sp_out         (sp_out),
        .state_out      (state_out),
        .entry_out      (entry_out),
        .size_out       (size_out),
        .switch_request (switch_request)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stack top of a slot under the current base, wrapping at 32 bits
    function automatic logic [31:0] top_of(int slot);
        return area_base + 32'((slot + 1) * SLOT_BYTES);
    endfunction

    // Next ready user task after the current one, 0 if none
    function automatic logic [3:0] next_ready();
        int t;
        for (int i = 1; i <= NUM_TASKS; i++)
        begin
            t = (int'(cur_task) + i) % NUM_TASKS;
            if (t != 0 && slot_state[t] == TS_READY)
                return 4'(t);
        end
        return 4'd0;
    endfunction

    // Apply one kernel call to the mirror and return its reply
    function automatic tts_res_t run_kernel_call(input call_t c);
        tts_res_t   r;
        int         free_slot;
        logic [3:0] nxt;
        r = '0;
        case (c.op)
            OP_INIT:
            begin
                sched_on = 1'b0;
                cur_task = '0;
                for (int i = 0; i < NUM_TASKS; i++)
                begin
                    slot_state[i] = TS_DORMANT;
                    slot_entry[i] = '0;
                    slot_size[i]  = '0;
                    slot_sp[i]    = '0;
                end
                slot_size[0]  = min_stack;
                slot_sp[0]    = top_of(0) - FRAME_BYTES;
                slot_state[0] = TS_READY;
                table_ready   = 1'b1;
            end
            OP_CREATE:
            begin
                free_slot = 0;
                for (int i = NUM_TASKS - 1; i >= 1; i--)
                    if (slot_state[i] == TS_DORMANT)
                        free_slot = i;
                if (!table_ready || c.entry == 0 || c.sbytes < min_stack ||
                    (c.sbytes & ALIGN_MASK) != 0 || free_slot == 0 ||
                    int'(c.sbytes) > SLOT_BYTES)
                    r.status = 1'b1;
                else
                begin
                    slot_entry[free_slot] = c.entry;
                    slot_size[free_slot]  = c.sbytes;
                    slot_sp[free_slot]    = top_of(free_slot) - FRAME_BYTES;
                    slot_state[free_slot] = TS_READY;
                    r.id  = 4'(free_slot);
                    r.top = top_of(free_slot);
                    r.sp  = slot_sp[free_slot];
                end
            end
            OP_START:
            begin
                if (!table_ready || sched_on || next_ready() == 0)
                    r.status = 1'b1;
                else
                begin
                    sched_on = 1'b1;
                    r.req    = 1'b1;
                end
            end
            OP_YIELD:
                r.req = sched_on;
            OP_EXIT:
            begin
                if (!sched_on || cur_task == 0 || slot_state[cur_task] != TS_RUNNING)
                    r.status = 1'b1;
                else
                begin
                    slot_state[cur_task] = TS_DORMANT;
                    r.req = 1'b1;
                end
            end
            OP_SWITCH:
            begin
                if (c.osp != 0 && slot_state[cur_task] == TS_RUNNING)
                begin
                    slot_sp[cur_task]    = c.osp;
                    slot_state[cur_task] = TS_READY;
                end
                nxt = next_ready();
                if (slot_state[nxt] != TS_READY)
                begin
                    r.id = cur_task;
                    r.sp = c.osp;
                end
                else
                begin
                    cur_task        = nxt;
                    slot_state[nxt] = TS_RUNNING;
                    r.id = nxt;
                    r.sp = slot_sp[nxt];
                end
            end
            OP_INFO:
            begin
                if (!table_ready || int'(c.qid) >= NUM_TASKS || slot_state[c.qid] == TS_DORMANT)
                    r.status = 1'b1;
                else
                begin
                    r.id     = c.qid;
                    r.top    = top_of(int'(c.qid));
                    r.sp     = slot_sp[c.qid];
                    r.tstate = slot_state[c.qid];
                    r.entry  = slot_entry[c.qid];
                    r.size   = slot_size[c.qid];
                end
            end
            OP_GETID:
                r.id = sched_on ? cur_task : 4'd0;
            default:
                r = '0;
        endcase
        return r;
    endfunction

    function automatic call_t call_of(tts_op_t op, logic [15:0] sb, logic [31:0] ent,
                                      logic [3:0] qid, logic [31:0] osp);
        call_t c;
        c.op     = op;
        c.sbytes = sb;
        c.entry  = ent;
        c.qid    = qid;
        c.osp    = osp;
        return c;
    endfunction

    // Mostly well-formed calls with random content, some pure noise
    function automatic call_t random_call();
        call_t c;
        int    pick;
        int    lo;
        c.op     = OP_GETID;
        c.sbytes = 16'($urandom);
        c.entry  = 32'($urandom);
        c.qid    = 4'($urandom);
        c.osp    = 32'($urandom);
        pick     = $urandom_range(0, 99);
        if (pick < 12)
            c.op = tts_op_t'($urandom_range(0, 7));
        else if (pick < 40)
        begin
            c.op = OP_CREATE;
            lo   = (int'(min_stack) + 7) / 8 * 8;
            if (lo <= SLOT_BYTES)
                c.sbytes = 16'(lo + 8 * $urandom_range(0, (SLOT_BYTES - lo) / 8));
            // break the size or entry now and then
            if ($urandom_range(0, 9) == 0)
                c.sbytes = c.sbytes | 16'($urandom_range(1, 7));
            if ($urandom_range(0, 19) == 0)
                c.entry = '0;
            else if (c.entry == 0)
                c.entry = 32'h0800_0001;
        end
        else if (pick < 64)
        begin
            c.op = OP_SWITCH;
            if ($urandom_range(0, 5) == 0)
                c.osp = '0;
        end
        else if (pick < 76)
            c.op = OP_INFO;
        else if (pick < 86)
            c.op = OP_EXIT;
        else if (pick < 92)
            c.op = OP_START;
        else if (pick < 95)
            c.op = OP_YIELD;
        else if (pick < 98)
            c.op = OP_GETID;
        else
            c.op = OP_INIT;
        return c;
    endfunction

    task automatic drop_start();
        if (start_high)
        begin
            start      <= 1'b0;
            start_high  = 1'b0;
        end
    endtask

    // Drive one item, wait until it is taken, and queue its reply
    task automatic issue(input call_t c);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            drop_start();
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        start       <= 1'b1;
        start_high   = 1'b1;
        mode        <= c.op;
        stack_bytes <= c.sbytes;
        entry_addr  <= c.entry;
        query_id    <= c.qid;
        outgoing_sp <= c.osp;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        reply_q.push_back(run_kernel_call(c));
        items_sent++;
    endtask

    // Write one register once the block has gone quiet, then read it back
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        drop_start();
        while (reply_q.size() != 0)
            @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_BASE)
            area_base = data;
        else
            min_stack = data[15:0];
        reg_writes++;
        @(posedge clk);
        if (addr == ADDR_BASE)
            check_field("prdata", area_base, prdata);
        else
            check_field("prdata", {16'd0, min_stack}, prdata);
    endtask

    task automatic test_before_init();
        issue(call_of(OP_SWITCH, 16'd0, 32'd0, 4'd0, 32'hFFFF_FFFC));
        issue(call_of(OP_CREATE, 16'd1024, 32'h0800_0000, 4'd0, 32'd0));
        issue(call_of(OP_START, 16'd0, 32'd0, 4'd0, 32'd0));
        issue(call_of(OP_INFO, 16'd0, 32'd0, 4'd0, 32'd0));
        issue(call_of(OP_YIELD, 16'd0, 32'd0, 4'd0, 32'd0));
        issue(call_of(OP_EXIT, 16'd0, 32'd0, 4'd0, 32'd0));
        issue(call_of(OP_GETID, 16'd0, 32'd0, 4'd0, 32'd0));
    endtask

    task automatic test_create_checks();
        issue(call_of(OP_INIT, 16'd0, 32'd0, 4'd0, 32'd0));
        issue(call_of(OP_CREATE, 16'd512, 32'd0, 4'd0, 32'd0));
        issue(call_of(OP_CREATE, 16'd504, 32'h0800_0100, 4'd0, 32'd0));
        issue(call_of(OP_CREATE, 16'd516, 32'h0800_0100, 4'd0, 32'd0));
        issue(call_of(OP_CREATE, 16'd2056, 32'h0800_0100, 4'd0, 32'd0));
        issue(call_of(OP_CREATE, 16'hFFF8, 32'h0800_0100, 4'd0, 32'd0));
        issue(call_of(OP_CREATE, 16'd2048, 32'hFFFF_FFFF, 4'd0, 32'd0));
        issue(call_of(OP_CREATE, 16'd512, 32'h0000_0001, 4'd0, 32'd0));
        issue(call_of(OP_INFO, 16'd0, 32'd0, 4'd0, 32'd0));
        issue(call_of(OP_INFO, 16'd0, 32'd0, 4'd1, 32'd0));
        issue(call_of(OP_INFO, 16'd0, 32'd0, 4'd15, 32'd0));
    endtask

    task automatic test_full_table();
        for (int i = 3; i < NUM_TASKS; i++)
            issue(call_of(OP_CREATE, 16'd1024, 32'h0800_0000 + 32'(i), 4'd0, 32'd0));
        issue(call_of(OP_CREATE, 16'd1024, 32'h0800_0040, 4'd0, 32'd0));
        issue(call_of(OP_INFO, 16'd0, 32'd0, 4'd15, 32'd0));
    endtask

    task automatic test_scheduling();
        issue(call_of(OP_START, 16'd0, 32'd0, 4'd0, 32'd0));
        issue(call_of(OP_START, 16'd0, 32'd0, 4'd0, 32'd0));
        issue(call_of(OP_GETID, 16'd0, 32'd0, 4'd0, 32'd0));
        issue(call_of(OP_SWITCH, 16'd0, 32'd0, 4'd0, 32'd0));
        issue(call_of(OP_SWITCH, 16'd0, 32'd0, 4'd0, 32'h1234_5678));
        issue(call_of(OP_YIELD, 16'd0, 32'd0, 4'd0, 32'd0));
        issue(call_of(OP_EXIT, 16'd0, 32'd0, 4'd0, 32'd0));
        issue(call_of(OP_EXIT, 16'd0, 32'd0, 4'd0, 32'd0));
        issue(call_of(OP_SWITCH, 16'd0, 32'd0, 4'd0, 32'hFFFF_FFFF));
        issue(call_of(OP_INFO, 16'd0, 32'd0, 4'd1, 32'd0));
        issue(call_of(OP_GETID, 16'd0, 32'd0, 4'd0, 32'd0));
    endtask

    task automatic test_register_extremes();
        // info must pick up the new base; the top wraps past 2^32
        write_reg(ADDR_BASE, 32'hFFFF_FFFF);
        issue(call_of(OP_INFO, 16'd0, 32'd0, 4'd15, 32'd0));
        write_reg(ADDR_MIN, 32'h0000_FFFF);
        issue(call_of(OP_CREATE, 16'd2048, 32'h0800_0200, 4'd0, 32'd0));
        write_reg(ADDR_MIN, 32'hFFFF_0000);
        issue(call_of(OP_CREATE, 16'd0, 32'h0800_0300, 4'd0, 32'd0));
        issue(call_of(OP_INFO, 16'd0, 32'd0, 4'd2, 32'd0));
    endtask

    task automatic test_random_traffic();
        logic [31:0] base_pick [NUM_PHASES];
        logic [15:0] min_pick  [NUM_PHASES];
        base_pick = '{32'h2000_0000, 32'($urandom), 32'hFFFF_F800, 32'($urandom), 32'h0};
        min_pick  = '{16'd512, 16'd8, 16'd0, 16'($urandom_range(1, 2048)), 16'd2048};
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            // the last phase runs back to back
            gaps_on = (p < NUM_PHASES - 1);
            write_reg(ADDR_BASE, base_pick[p]);
            write_reg(ADDR_MIN, {16'($urandom), min_pick[p]});
            issue(call_of(OP_INIT, 16'($urandom), 32'($urandom), 4'($urandom), 32'($urandom)));
            repeat (PER_PHASE)
                issue(random_call());
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Compare each reply with the oldest one queued
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            replies++;
            if (reply_q.size() == 0)
            begin
                $display("%0t: reply with none expected, expected nothing, actual id %h",
                         $time, id_out);
                errors++;
            end
            else
            begin
                want_reply = reply_q.pop_front();
                check_field("status", 32'(want_reply.status), 32'(status));
                check_field("id_out", 32'(want_reply.id), 32'(id_out));
                check_field("stack_top_out", want_reply.top, stack_top_out);
                check_field("sp_out", want_reply.sp, sp_out);
                check_field("state_out", 32'(want_reply.tstate), 32'(state_out));
                check_field("entry_out", want_reply.entry, entry_out);
                check_field("size_out", 32'(want_reply.size), 32'(size_out));
                check_field("switch_request", 32'(want_reply.req), 32'(switch_request));
            end
        end
    end

    // Stop the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cnt = 0;
            else
            begin
                stall_cnt++;
                if (stall_cnt >= STALL_LIMIT)
                begin
                    $display("task_table_round_robin_scheduler_test failed");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            slot_state[i] = TS_DORMANT;
            slot_entry[i] = '0;
            slot_size[i]  = '0;
            slot_sp[i]    = '0;
        end
        cur_task    = '0;
        table_ready = 1'b0;
        sched_on    = 1'b0;
        area_base   = '0;
        min_stack   = MIN_STACK_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_init();
        test_create_checks();
        test_full_table();
        test_scheduling();
        test_register_extremes();
        test_random_traffic();

        // Drain outstanding replies and let the sequencer settle
        drop_start();
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (NUM_TASKS + 8) @(posedge clk);

        $display("Sent %0d kernel calls, checked %0d replies, %0d register writes.",
                 items_sent, replies, reg_writes);
        $display("Covered all operations, every rejection, full table and base wrap-around.");
        if (errors == 0 && reply_q.size() == 0)
            $display("task_table_round_robin_scheduler_test passed");
        else
            $display("task_table_round_robin_scheduler_test failed");
        $finish;
    end

endmodule

`default_nettype wire
